### rtl/assert_macros.svh
// Assertion macros shared by the distance scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define DSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define DSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/dss_pkg.sv
// Package with types, constants and glyph functions of the distance scanner.
package dss_pkg;

  localparam int BAR_STEP      = 500;
  localparam int NUM_POSITIONS = 7;
  localparam int POS_W         = 3;
  localparam int NUM_DIGITS    = 5;
  localparam int FRONT_STAGES  = NUM_DIGITS - 1;
  localparam int BAR_LEVELS    = 8;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW      = $clog2(QUEUE_DEPTH + 1);

  localparam int POS_DP  = 1;
  localparam int POS_BAR = 6;

  localparam logic [15:0] TICKS_RESET = 16'd200;
  localparam logic [7:0]  BLANK       = 8'hFF;
  localparam logic [7:0]  DP_MASK     = 8'h7F;

  // x / 10 == (x * 52429) >> 19 holds for every 16-bit x.
  localparam logic [16:0] DIV10_MUL   = 17'd52429;
  localparam int          DIV10_SHIFT = 19;

  typedef enum logic {
    MODE_DISTANCE = 1'b0,
    MODE_TICK     = 1'b1
  } dss_mode_t;

  typedef struct packed {
    dss_mode_t                       mode;
    logic [15:0]                     quot;
    logic [NUM_DIGITS-2:0][3:0]      digits;
    logic [2:0]                      bar;
  } dss_stage_t;

  typedef struct packed {
    dss_mode_t                       mode;
    logic [NUM_DIGITS-1:0][3:0]      digits;
    logic [2:0]                      bar;
  } dss_item_t;

  typedef struct packed {
    logic      valid;
    dss_item_t item;
  } dss_head_t;

  function automatic logic [15:0] div10(input logic [15:0] v);
    logic [32:0] prod;
    prod = 33'(v) * 33'(DIV10_MUL);
    return prod[DIV10_SHIFT +: 16];
  endfunction

  function automatic logic [3:0] rem10(input logic [15:0] v, input logic [15:0] q);
    logic [15:0] r;
    r = v - ((q << 3) + (q << 1));
    return r[3:0];
  endfunction

  function automatic logic [7:0] digit_glyph(input logic [3:0] d);
    logic [7:0] g;
    unique case (d)
      4'd0:    g = 8'hC0;
      4'd1:    g = 8'hF9;
      4'd2:    g = 8'hA4;
      4'd3:    g = 8'hB0;
      4'd4:    g = 8'h99;
      4'd5:    g = 8'h92;
      4'd6:    g = 8'h82;
      4'd7:    g = 8'hF8;
      4'd8:    g = 8'h80;
      4'd9:    g = 8'h90;
      default: g = BLANK;
    endcase
    return g;
  endfunction

  function automatic logic [7:0] bar_glyph(input logic [2:0] idx);
    logic [7:0] g;
    unique case (idx)
      3'd0:    g = 8'h7F;
      3'd1:    g = 8'h3F;
      3'd2:    g = 8'h1F;
      3'd3:    g = 8'h0F;
      3'd4:    g = 8'h07;
      3'd5:    g = 8'h03;
      3'd6:    g = 8'h01;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

### rtl/dss_front.sv
// Front end: accepts requests and splits distances into decimal digits over stages.
module dss_front import dss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [15:0] in_distance_value,
  output logic        dn_valid,
  input  logic        dn_ready,
  output dss_item_t   dn_item
);

  dss_stage_t                stage_r   [FRONT_STAGES];
  dss_stage_t                stage_nxt [FRONT_STAGES];
  logic [FRONT_STAGES-1:0]   valid_r;
  logic [FRONT_STAGES-1:0]   valid_nxt;
  logic [FRONT_STAGES-1:0]   stage_ready;

  // A stage takes new data when it is empty or its content moves on.
  always_comb begin
    stage_ready[FRONT_STAGES-1] = !valid_r[FRONT_STAGES-1] || dn_ready;
    for (int s = FRONT_STAGES - 2; s >= 0; s--) begin
      stage_ready[s] = !valid_r[s] || stage_ready[s+1];
    end
  end

  always_comb begin
    stage_nxt[0].mode      = dss_mode_t'(in_mode);
    stage_nxt[0].quot      = div10(in_distance_value);
    stage_nxt[0].digits    = '0;
    stage_nxt[0].digits[0] = rem10(in_distance_value, stage_nxt[0].quot);
    // Bar index is (d-1)/BAR_STEP clamped to the top level; zero gives level zero.
    stage_nxt[0].bar = '0;
    for (int i = 1; i < BAR_LEVELS; i++) begin
      if (17'(in_distance_value) > 17'(BAR_STEP * i)) begin
        stage_nxt[0].bar = 3'(i);
      end
    end
    for (int s = 1; s < FRONT_STAGES; s++) begin
      stage_nxt[s]           = stage_r[s-1];
      stage_nxt[s].quot      = div10(stage_r[s-1].quot);
      stage_nxt[s].digits[s] = rem10(stage_r[s-1].quot, stage_nxt[s].quot);
    end
  end

  always_comb begin
    valid_nxt[0] = stage_ready[0] ? in_valid : valid_r[0];
    for (int s = 1; s < FRONT_STAGES; s++) begin
      valid_nxt[s] = stage_ready[s] ? valid_r[s-1] : valid_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < FRONT_STAGES; s++) begin
      if (stage_ready[s]) begin
        stage_r[s] <= stage_nxt[s];
      end
    end
  end

  assign in_ready = stage_ready[0];
  assign dn_valid = valid_r[FRONT_STAGES-1];

  always_comb begin
    dn_item.mode                     = stage_r[FRONT_STAGES-1].mode;
    dn_item.bar                      = stage_r[FRONT_STAGES-1].bar;
    dn_item.digits[NUM_DIGITS-2:0]   = stage_r[FRONT_STAGES-1].digits;
    dn_item.digits[NUM_DIGITS-1]     = stage_r[FRONT_STAGES-1].quot[3:0];
  end

endmodule

### rtl/dss_queue.sv
// Short queue between the front end and the display back end.
module dss_queue import dss_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  dss_item_t push_item,
  output dss_head_t head,
  input  logic      pop
);

  `include "assert_macros.svh"

  dss_item_t             mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0]   count_r, count_nxt;
  logic                  push;

  assign push_ready = (count_r != QUEUE_CW'(QUEUE_DEPTH));
  assign push       = push_valid && push_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + QUEUE_CW'(push) - QUEUE_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head.valid = (count_r != '0);
  assign head.item  = mem_r[rd_ptr_r];

  `DSS_ASSERT(a_count_in_range, count_r <= QUEUE_CW'(QUEUE_DEPTH), "queue count above depth")
  `DSS_ASSERT(a_no_pop_empty, !pop || (count_r != '0), "pop from an empty queue")

endmodule

### rtl/dss_back.sv
// Back end: updates the display bytes and drives one position per tick.
module dss_back import dss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dss_head_t   head,
  output logic        pop,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_position_select,
  output logic [7:0]  out_segment_pattern,
  output logic        out_measure_request
);

  `include "assert_macros.svh"

  logic [7:0]        display_r   [NUM_POSITIONS];
  logic [7:0]        display_nxt [NUM_POSITIONS];
  logic [POS_W-1:0]  scan_pos_r, scan_pos_nxt;
  logic [15:0]       tick_count_r, tick_count_nxt;
  logic [15:0]       ticks_per_request_r;
  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_pos_r, out_pos_nxt;
  logic [7:0]        out_seg_r, out_seg_nxt;
  logic              out_req_r, out_req_nxt;

  logic              is_tick, is_dist, tick_pop;
  logic [15:0]       count_inc;
  logic              req_hit;
  logic [NUM_DIGITS-1:0] shown;

  assign is_tick  = head.valid && (head.item.mode == MODE_TICK);
  assign is_dist  = head.valid && (head.item.mode == MODE_DISTANCE);
  assign pop      = is_dist || (is_tick && (!out_valid_r || out_ready));
  assign tick_pop = is_tick && pop;

  assign count_inc = tick_count_r + 16'd1;
  assign req_hit   = (count_inc >= ticks_per_request_r);

  // A digit is shown when it or any higher digit is nonzero; digit 0 always shows.
  always_comb begin
    shown[NUM_DIGITS-1] = (head.item.digits[NUM_DIGITS-1] != 4'd0);
    for (int k = NUM_DIGITS - 2; k >= 1; k--) begin
      shown[k] = shown[k+1] || (head.item.digits[k] != 4'd0);
    end
    shown[0] = 1'b1;
  end

  always_comb begin
    for (int p = 0; p < NUM_POSITIONS; p++) begin
      display_nxt[p] = display_r[p];
    end
    if (is_dist) begin
      for (int k = 0; k < NUM_DIGITS; k++) begin
        display_nxt[k] = shown[k] ? digit_glyph(head.item.digits[k]) : BLANK;
      end
      display_nxt[POS_DP]  = display_nxt[POS_DP] & DP_MASK;
      display_nxt[POS_BAR] = bar_glyph(head.item.bar);
    end
  end

  always_comb begin
    scan_pos_nxt   = scan_pos_r;
    tick_count_nxt = tick_count_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_pos_nxt    = out_pos_r;
    out_seg_nxt    = out_seg_r;
    out_req_nxt    = out_req_r;
    if (tick_pop) begin
      scan_pos_nxt   = (scan_pos_r < POS_W'(NUM_POSITIONS - 1)) ? scan_pos_r + 1'b1 : '0;
      tick_count_nxt = req_hit ? '0 : count_inc;
      out_valid_nxt  = 1'b1;
      out_pos_nxt    = scan_pos_r;
      out_seg_nxt    = display_r[scan_pos_r];
      out_req_nxt    = req_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_POSITIONS; p++) begin
        display_r[p] <= BLANK;
      end
      scan_pos_r          <= '0;
      tick_count_r        <= '0;
      ticks_per_request_r <= TICKS_RESET;
      out_valid_r         <= 1'b0;
    end else begin
      for (int p = 0; p < NUM_POSITIONS; p++) begin
        display_r[p] <= display_nxt[p];
      end
      scan_pos_r   <= scan_pos_nxt;
      tick_count_r <= tick_count_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) begin
        ticks_per_request_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_pos_r <= out_pos_nxt;
    out_seg_r <= out_seg_nxt;
    out_req_r <= out_req_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_position_select = out_pos_r;
  assign out_segment_pattern = out_seg_r;
  assign out_measure_request = out_req_r;

  `DSS_ASSERT(a_scan_in_range, scan_pos_r <= POS_W'(NUM_POSITIONS - 1), "scan position out of range")
  `DSS_ASSERT_NXT(a_req_clears_count, tick_pop && req_hit, tick_count_r == '0, "request left count set")

endmodule

### rtl/distance_seven_segment_scanner_unit.sv
// Top level of the distance scanner for a multiplexed seven-segment display.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_ready   in_mode, in_distance_value
//   out_     output     out_valid / out_ready position, pattern, request
//   cfg_     input      cfg_wr_en             cfg_wr_data (ticks per request)
//
// One request is accepted per cycle while in_ready is high; each passes the digit split
// stages (one divide by ten per stage) and the two-entry queue, and a tick
// shows its result in the cycle after the back end takes it.
// Reset is synchronous on rst_n; all positions read blank afterwards.
// A stalled output holds one result while the queue and stages keep filling.
module distance_seven_segment_scanner_unit import dss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [15:0] in_distance_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_position_select,
  output logic [7:0]  out_segment_pattern,
  output logic        out_measure_request,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic      fq_valid;
  logic      fq_ready;
  dss_item_t fq_item;
  dss_head_t q_head;
  logic      q_pop;

  dss_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_distance_value (in_distance_value),
    .dn_valid          (fq_valid),
    .dn_ready          (fq_ready),
    .dn_item           (fq_item)
  );

  dss_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .head       (q_head),
    .pop        (q_pop)
  );

  dss_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head                (q_head),
    .pop                 (q_pop),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_position_select (out_position_select),
    .out_segment_pattern (out_segment_pattern),
    .out_measure_request (out_measure_request)
  );

endmodule
